// ----- rtl/csrc_pkg.sv -----
`default_nettype none

package csrc_pkg;

  // Item kinds carried in s_tuser
  typedef enum logic [1:0] {
    KIND_BARRIER = 2'd0,
    KIND_SITE    = 2'd1,
    KIND_END     = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Saturating counter step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/call_site_range_coalescer.sv -----
// Flow: a barrier is written to the table and a first site is held as pending,
//   both in IDLE; a later site walks past barriers, then merges or is emitted.
// The barrier cursor only moves forward, so the walk in the table RAM read port
//   costs about one extra read per site over a function. An end item goes to EMIT.
// Results sit in an output register; a stalled output holds the block in EMIT.
// Reset (rst, synchronous) empties the table, pending site and counters at once.
`default_nettype none

module call_site_range_coalescer
  import csrc_pkg::*;
#(
  parameter int MAX_BARRIERS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // position, span, pad_target, action_entry
  input  wire logic [127:0] s_tdata,
  // kind
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // site_start, site_length, site_pad, site_action, kept_count, merged_count
  output logic [159:0]      m_tdata,
  // has_site, final_res
  output logic [1:0]        m_tuser
);

  localparam int AW = (MAX_BARRIERS > 1) ? $clog2(MAX_BARRIERS) : 1;
  localparam int CW = $clog2(MAX_BARRIERS + 1);

  state_t state, state_next;

  // latched input item
  kind_t       in_kind;
  logic [31:0] in_pos, in_span, in_pad, in_act;

  // pending site
  logic        pend_valid;
  logic [31:0] pend_start, pend_length, pend_pad, pend_act;

  logic [CW-1:0]    fill, cursor;
  logic [CNT_W-1:0] kept_total, merged_total;

  // output register
  logic        out_valid, out_has, out_final;
  logic [31:0] out_start, out_length, out_pad, out_act;
  logic [CNT_W-1:0] out_kept, out_merged;

  logic        accept, slot_free, walk_hit, adv, gap, same, do_merge, do_emit;
  logic        wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0] rdata;
  logic [32:0] prev_end, cur_end, max_end, new_len;
  logic [CW-1:0] cursor_inc;
  kind_t       s_kind;

  assign s_kind     = kind_t'(s_tuser);
  assign accept     = s_tvalid && s_tready;
  assign slot_free  = !out_valid || m_tready;
  assign cursor_inc = cursor + 1'b1;

  // walk and merge arithmetic
  assign prev_end = {1'b0, pend_start} + {1'b0, pend_length};
  assign cur_end  = {1'b0, in_pos} + {1'b0, in_span};
  assign max_end  = (cur_end < prev_end) ? prev_end : cur_end;
  assign new_len  = max_end - {1'b0, pend_start};
  assign walk_hit = cursor < fill;
  assign gap      = walk_hit && (rdata < in_pos);
  assign same     = (in_pad == pend_pad) && (in_act == pend_act);

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    adv      = 1'b0;
    do_merge = 1'b0;
    do_emit  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_WALK: begin
        if (walk_hit && ({1'b0, rdata} < prev_end)) begin
          adv = 1'b1;
        end else if (!gap && same) begin
          do_merge = 1'b1;
        end else begin
          do_emit = slot_free;
        end
      end
      ST_EMIT: begin
        do_emit = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign wr_en   = accept && (s_kind == KIND_BARRIER) && (fill < CW'(MAX_BARRIERS));
  assign rd_en   = adv || (accept && (s_kind == KIND_SITE) && pend_valid);
  assign rd_addr = adv ? cursor_inc[AW-1:0] : cursor[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_kind == KIND_SITE && pend_valid) begin
            state_next = ST_WALK;
          end else if (s_kind == KIND_END) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        if (do_merge || do_emit) begin
          state_next = ST_IDLE;
        end else if (!adv) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (do_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind <= s_kind;
      in_pos  <= s_tdata[31:0];
      in_span <= s_tdata[63:32];
      in_pad  <= s_tdata[95:64];
      in_act  <= s_tdata[127:96];
    end
  end

  // pending site, table bookkeeping and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      fill         <= '0;
      cursor       <= '0;
      kept_total   <= '0;
      merged_total <= '0;
    end else begin
      if (wr_en) begin
        fill <= fill + 1'b1;
      end
      if (accept && s_kind == KIND_SITE && !pend_valid) begin
        pend_valid  <= 1'b1;
        pend_start  <= s_tdata[31:0];
        pend_length <= s_tdata[63:32];
        pend_pad    <= s_tdata[95:64];
        pend_act    <= s_tdata[127:96];
      end
      if (adv) begin
        cursor <= cursor_inc;
      end
      if (do_merge) begin
        pend_length  <= new_len[32] ? 32'hFFFF_FFFF : new_len[31:0];
        merged_total <= sat_inc(merged_total);
      end
      if (do_emit) begin
        if (in_kind == KIND_END) begin
          pend_valid   <= 1'b0;
          fill         <= '0;
          cursor       <= '0;
          kept_total   <= '0;
          merged_total <= '0;
        end else begin
          kept_total  <= sat_inc(kept_total);
          pend_start  <= in_pos;
          pend_length <= in_span;
          pend_pad    <= in_pad;
          pend_act    <= in_act;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      if (in_kind == KIND_END) begin
        out_has    <= pend_valid;
        out_final  <= 1'b1;
        out_start  <= pend_valid ? pend_start : '0;
        out_length <= pend_valid ? pend_length : '0;
        out_pad    <= pend_valid ? pend_pad : '0;
        out_act    <= pend_valid ? pend_act : '0;
        out_kept   <= pend_valid ? sat_inc(kept_total) : kept_total;
        out_merged <= merged_total;
      end else begin
        out_has    <= 1'b1;
        out_final  <= 1'b0;
        out_start  <= pend_start;
        out_length <= pend_length;
        out_pad    <= pend_pad;
        out_act    <= pend_act;
        out_kept   <= '0;
        out_merged <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_merged, out_kept, out_act, out_pad, out_length, out_start};
  assign m_tuser  = {out_final, out_has};

  // barrier table
  csrc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BARRIERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill[AW-1:0]),
    .wdata (s_tdata[31:0]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/csrc_ram.sv -----
`default_nettype none

module csrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csrc_checker.sv -----
`default_nettype none

module csrc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [159:0] m_tdata,
  input wire logic [1:0]   m_tuser
);

  // a stalled item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  // a stalled item keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // a non-final result always carries a site and no counts
  a_site_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tuser[0] && (m_tdata[159:128] == 32'd0))
    else $error("site result malformed");

  // a final result without a site has zero site fields
  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && !m_tuser[0] |-> (m_tdata[127:0] == 128'd0))
    else $error("empty final result carries site data");

endmodule

bind call_site_range_coalescer csrc_checker u_csrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
